>>> sv/wbps_pkg.sv
// Package for the wildcard byte pattern scanner.
// Holds window sizes, register map codes and the configuration struct.
// No dependencies.
package wbps_pkg;

    localparam int WIN_DEPTH = 16;
    localparam int IDX_W     = 4;
    localparam int LEN_W     = 5;
    localparam int CAP_BYTES = 8;
    localparam int ADDR_W    = 6;

    localparam logic [2:0] REG_PAT_LOW  = 3'd0;
    localparam logic [2:0] REG_PAT_HIGH = 3'd1;
    localparam logic [2:0] REG_SKIP     = 3'd2;
    localparam logic [2:0] REG_CAPTURE  = 3'd3;
    localparam logic [2:0] REG_LENGTH   = 3'd4;
    localparam logic [2:0] REG_MODE     = 3'd5;
    localparam logic [2:0] REG_BASE     = 3'd6;

    localparam logic MODE_ADDRESS = 1'b0;
    localparam logic MODE_CAPTURE = 1'b1;

    typedef struct packed {
        logic [63:0]          pat_low;
        logic [63:0]          pat_high;
        logic [WIN_DEPTH-1:0] skip_mask;
        logic [WIN_DEPTH-1:0] capture_mask;
        logic [LEN_W-1:0]     pattern_length;
        logic                 result_mode;
        logic [63:0]          base_address;
    } cfg_t;

endpackage

>>> sv/wbps_regs.sv
// Configuration register file of the wildcard byte pattern scanner.
// APB-style write/read port; depends on wbps_pkg.
module wbps_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wbps_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready,
    output wbps_pkg::cfg_t             cfg
);

    wbps_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pat_low        <= 64'd0;
            cfg_reg.pat_high       <= 64'd0;
            cfg_reg.skip_mask      <= '0;
            cfg_reg.capture_mask   <= '0;
            cfg_reg.pattern_length <= wbps_pkg::LEN_W'(1);
            cfg_reg.result_mode    <= wbps_pkg::MODE_ADDRESS;
            cfg_reg.base_address   <= 64'd0;
        end else if (wr_en) begin
            case (reg_idx)
                wbps_pkg::REG_PAT_LOW:  cfg_reg.pat_low        <= pwdata;
                wbps_pkg::REG_PAT_HIGH: cfg_reg.pat_high       <= pwdata;
                wbps_pkg::REG_SKIP:     cfg_reg.skip_mask      <= pwdata[15:0];
                wbps_pkg::REG_CAPTURE:  cfg_reg.capture_mask   <= pwdata[15:0];
                wbps_pkg::REG_LENGTH:   cfg_reg.pattern_length <= pwdata[4:0];
                wbps_pkg::REG_MODE:     cfg_reg.result_mode    <= pwdata[0];
                wbps_pkg::REG_BASE:     cfg_reg.base_address   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            wbps_pkg::REG_PAT_LOW:  prdata = cfg_reg.pat_low;
            wbps_pkg::REG_PAT_HIGH: prdata = cfg_reg.pat_high;
            wbps_pkg::REG_SKIP:     prdata = {48'd0, cfg_reg.skip_mask};
            wbps_pkg::REG_CAPTURE:  prdata = {48'd0, cfg_reg.capture_mask};
            wbps_pkg::REG_LENGTH:   prdata = {59'd0, cfg_reg.pattern_length};
            wbps_pkg::REG_MODE:     prdata = {63'd0, cfg_reg.result_mode};
            wbps_pkg::REG_BASE:     prdata = cfg_reg.base_address;
            default:                prdata = 64'd0;
        endcase
    end

endmodule

>>> sv/wildcard_byte_pattern_scanner.sv
// Top level of the wildcard byte pattern scanner: window, compare, result pipeline.
// Depends on wbps_pkg and wbps_regs.
//
//  channel   dir  handshake           content
//  s_        in   s_tvalid/s_tready   tdata = data_byte, tlast = last
//  m_        out  m_tvalid/m_tready   tdata = value, tuser = found
//  apb       in   psel/penable/pready configuration registers, 8-byte stride
//
// One byte per cycle while s_tready is high; the window shift and the compare
// finish in the accept cycle. A result passes a capture/address stage, then the
// output register. Reset is synchronous; the region state and the pipeline clear.
// s_tready drops only while both the capture stage and the output register are held.
module wildcard_byte_pattern_scanner (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] data_byte
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [63:0]                 m_tdata,   // [63:0] value
    output logic [0:0]                  m_tuser,   // [0] found
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wbps_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);

    localparam int D = wbps_pkg::WIN_DEPTH;

    wbps_pkg::cfg_t cfg;

    wbps_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // region state
    logic [7:0]                 win_reg  [D];
    logic [7:0]                 win_next [D];
    logic [wbps_pkg::LEN_W-1:0] seen_reg, seen_next;
    logic [wbps_pkg::LEN_W-1:0] seen_inc;
    logic [63:0]                offset_reg, offset_next;
    logic                       reported_reg, reported_next;

    // capture/address stage
    logic                       s2_valid_reg, s2_valid_next;
    logic                       s2_found_reg;
    logic                       s2_mode_reg;
    logic [7:0]                 s2_aligned_reg [D];
    logic [D-1:0]               s2_cap_reg;
    logic [63:0]                s2_base_reg;
    logic [63:0]                s2_start_reg;

    // output register
    logic                       m_valid_reg, m_valid_next;
    logic                       m_found_reg;
    logic [63:0]                m_value_reg;

    logic                       s_acc, out_free, s2_load;
    logic [wbps_pkg::LEN_W-1:0] len;
    logic [D-1:0]               len_mask;
    logic [7:0]                 aligned [D];
    logic [7:0]                 lit     [D];
    logic                       match;
    logic [63:0]                start_off;
    logic [63:0]                cap_value;
    logic [63:0]                s2_value;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !s2_valid_reg || out_free;
    assign s_acc    = s_tvalid && s_tready;

    // effective pattern length, 1..16
    always_comb begin
        if (cfg.pattern_length == '0) begin
            len = wbps_pkg::LEN_W'(1);
        end else if (cfg.pattern_length > wbps_pkg::LEN_W'(D)) begin
            len = wbps_pkg::LEN_W'(D);
        end else begin
            len = cfg.pattern_length;
        end
    end

    always_comb begin
        win_next[0] = s_tdata;
        for (int i = 1; i < D; i++) begin
            win_next[i] = win_reg[i-1];
        end
    end

    // bytes seen including the one being accepted, saturating at the depth
    assign seen_inc = (seen_reg < wbps_pkg::LEN_W'(D)) ? seen_reg + wbps_pkg::LEN_W'(1)
                                                       : seen_reg;

    // pattern position p sits at window index len-1-p
    always_comb begin
        logic [wbps_pkg::LEN_W-1:0] idx;
        match = (seen_inc >= len);
        for (int p = 0; p < D; p++) begin
            idx         = len - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(p);
            len_mask[p] = (wbps_pkg::LEN_W'(p) < len);
            aligned[p]  = win_next[idx[wbps_pkg::IDX_W-1:0]];
            lit[p]      = (p < 8) ? cfg.pat_low[8*(p%8) +: 8] : cfg.pat_high[8*(p%8) +: 8];
            if (len_mask[p] && !cfg.capture_mask[p] && !cfg.skip_mask[p] &&
                aligned[p] != lit[p]) begin
                match = 1'b0;
            end
        end
    end

    assign start_off = offset_reg - 64'(len - wbps_pkg::LEN_W'(1));
    assign s2_load   = s_acc && !reported_reg && (match || s_tlast);

    always_comb begin
        seen_next     = seen_reg;
        reported_next = reported_reg;
        offset_next   = offset_reg;
        if (s_acc) begin
            offset_next = offset_reg + 64'd1;
            if (!reported_reg) begin
                seen_next     = seen_inc;
                reported_next = match;
            end
            if (s_tlast) begin
                seen_next     = '0;
                offset_next   = 64'd0;
                reported_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= '0;
            offset_reg   <= 64'd0;
            reported_reg <= 1'b0;
            for (int i = 0; i < D; i++) begin
                win_reg[i] <= 8'd0;
            end
        end else begin
            seen_reg     <= seen_next;
            offset_reg   <= offset_next;
            reported_reg <= reported_next;
            if (s_acc && (s_tlast || !reported_reg)) begin
                for (int i = 0; i < D; i++) begin
                    win_reg[i] <= s_tlast ? 8'd0 : win_next[i];
                end
            end
        end
    end

    // capture stage
    assign s2_valid_next = s2_load ? 1'b1 : (out_free ? 1'b0 : s2_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s2_valid_next;
        end
        if (s2_load) begin
            s2_found_reg <= match;
            s2_mode_reg  <= cfg.result_mode;
            s2_cap_reg   <= cfg.capture_mask & len_mask;
            s2_base_reg  <= cfg.base_address;
            s2_start_reg <= start_off;
            for (int p = 0; p < D; p++) begin
                s2_aligned_reg[p] <= aligned[p];
            end
        end
    end

    // capture slots packed little-endian by rank among the slots
    always_comb begin
        logic [wbps_pkg::LEN_W-1:0] rank;
        cap_value = 64'd0;
        for (int p = 0; p < D; p++) begin
            rank = wbps_pkg::LEN_W'($countones(s2_cap_reg & ((D'(1) << p) - D'(1))));
            if (s2_cap_reg[p] && rank < wbps_pkg::LEN_W'(wbps_pkg::CAP_BYTES)) begin
                cap_value = cap_value | (64'(s2_aligned_reg[p]) << (8 * rank[2:0]));
            end
        end
    end

    always_comb begin
        if (!s2_found_reg) begin
            s2_value = 64'd0;
        end else if (s2_mode_reg == wbps_pkg::MODE_CAPTURE) begin
            s2_value = cap_value;
        end else begin
            s2_value = s2_base_reg + s2_start_reg;
        end
    end

    // output register
    assign m_valid_next = (s2_valid_reg && out_free) ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (s2_valid_reg && out_free) begin
            m_found_reg <= s2_found_reg;
            m_value_reg <= s2_value;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_value_reg;
    assign m_tuser[0] = m_found_reg;

    a_seen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= wbps_pkg::LEN_W'(D))
        else $error("bytes seen beyond window depth");

    a_last_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tlast |=> seen_reg == '0 && !reported_reg && offset_reg == 64'd0)
        else $error("region state not cleared after last");

    a_no_result_after_match: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && reported_reg |-> !s2_load)
        else $error("second result in one region");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_found_reg |-> m_value_reg == 64'd0)
        else $error("not-found result with nonzero value");

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_load |-> (!s2_valid_reg || out_free))
        else $error("capture stage overwritten");

endmodule
